// ===== rtl/nmea_pkg.sv =====
// ----------------------------------------------------------------------------
// nmea_pkg
// Shared types, character codes and arithmetic constants for the NMEA
// position sentence parser.
// ----------------------------------------------------------------------------
package nmea_pkg;

    localparam int FRACTION_DIGITS_DEF = 5;

    // Character codes
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Field numbers (text after comma k is field k)
    localparam logic [2:0] FLD_TIME   = 3'd1;
    localparam logic [2:0] FLD_STATUS = 3'd2;
    localparam logic [2:0] FLD_LAT    = 3'd3;
    localparam logic [2:0] FLD_NS     = 3'd4;
    localparam logic [2:0] FLD_LON    = 3'd5;
    localparam logic [2:0] FLD_EW     = 3'd6;

    // Accumulator saturation limits
    localparam logic [17:0] TIME_MAX = 18'd262143;
    localparam logic [17:0] LATW_MAX = 18'd16383;
    localparam logic [17:0] LONW_MAX = 18'd32767;

    // Conversion constants
    localparam logic [23:0] E7        = 24'd10000000;
    localparam logic [12:0] RECIP_100 = 13'd5243;       // ceil(2^19 / 100)
    localparam int          RECIP_SH  = 19;
    localparam logic [31:0] RECIP_15  = 32'h11111112;   // ceil(2^32 / 15)
    localparam logic [31:0] LAT_LIMIT = 32'd900000000;
    localparam logic [31:0] LON_LIMIT = 32'd1800000000;

    // Weight of fraction digit j (0 = first after the point), 7-digit scale
    localparam logic [23:0] POW10 [0:6] = '{
        24'd1000000, 24'd100000, 24'd10000, 24'd1000, 24'd100, 24'd10, 24'd1
    };

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NO_SEP = 2'd1,
        ST_TRUNC  = 2'd2
    } status_t;

    // Non-position part of a result, carried along the conversion stages
    typedef struct packed {
        status_t     status;
        logic [17:0] utc;
        logic        fix;
        logic        north;
        logic        east;
    } side_t;

    // acc * 10 + d, saturated at lim
    function automatic logic [17:0] acc_sat(input logic [17:0] acc,
                                            input logic [3:0]  d,
                                            input logic [17:0] lim);
        logic [21:0] v;
        v = 22'(acc) * 22'd10 + 22'(d);
        return (v > 22'(lim)) ? lim : v[17:0];
    endfunction

endpackage

// ===== rtl/nmea_position_field_parser_top.sv =====
// ----------------------------------------------------------------------------
// nmea_position_field_parser_top
// Character-stream RMC-style sentence parser producing UTC time, fix flag,
// and latitude/longitude in degrees * 1e7.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one ASCII character per transfer in s_tdata[7:0];
//   s_tuser marks the first character of a new sentence and clears field
//   progress (the fix flag is kept). Until such a start, characters are
//   dropped.
//   Master channel: one result transfer per sentence, at the seventh comma
//   (status OK) or at a CR/LF before it (status no-separator / truncated,
//   position and time fields zero).
//   Throughput: one character per cycle, also across results, unless stalled as below.
//   Path: a result for the character that closes the sentence passes the
//   input register, parser into the capture stage, then divide by 100,
//   remainder and degrees * 1e7, minutes at 1e7 scale, divide by 60, and
//   the add-and-saturate output register before it shows on m_tvalid.
//   Stall: the stages form an elastic pipeline; bubbles are squeezed out
//   and s_tready only drops when a result-producing character waits while
//   every stage downstream of the parser holds a result and m_tready is
//   low. Other characters keep flowing even then.
//   Reset (rst_n low, asynchronous): pipeline empty, fix flag clear, parser
//   waiting for a sentence start.
// ----------------------------------------------------------------------------
module nmea_position_field_parser_top
    import nmea_pkg::*;
#(
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF   // 1..7
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tuser,   // [0] sentence_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [17:0] utc_hhmmss, [18] fix_valid,
                                   // [48:19] latitude_e7, [49] is_north,
                                   // [80:50] longitude_e7, [81] is_east, zero pad
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam logic [3:0] FD = 4'(FRACTION_DIGITS);

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_start_reg;
    logic       in_fire;

    // Parser state
    logic [2:0]  fld_reg, fld_next;
    logic        done_reg, done_next;
    logic        point_reg, point_next;
    logic [2:0]  fcnt_reg, fcnt_next;
    logic        started_reg, started_next;
    logic [17:0] time_reg, time_next;
    logic [13:0] latw_reg, latw_next;
    logic [23:0] latf_reg, latf_next;
    logic [14:0] lonw_reg, lonw_next;
    logic [23:0] lonf_reg, lonf_next;
    logic        north_reg, north_next;
    logic        east_reg, east_next;
    logic        fix_reg, fix_next;

    // Parser result
    logic        emit;
    side_t       emit_side;
    logic [13:0] emit_latw;
    logic [23:0] emit_latf;
    logic [14:0] emit_lonw;
    logic [23:0] emit_lonf;

    // Pipeline stage valids and free flags
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg;
    logic f_valid_reg;
    logic a_free, b_free, c_free, d_free, e_free, f_free;

    // Stage payloads
    side_t       a_side_reg, b_side_reg, c_side_reg, d_side_reg, e_side_reg;
    side_t       f_side_reg;
    logic [13:0] a_latw_reg, b_latw_reg;
    logic [14:0] a_lonw_reg, b_lonw_reg;
    logic [23:0] a_latf_reg, b_latf_reg, c_latf_reg;
    logic [23:0] a_lonf_reg, b_lonf_reg, c_lonf_reg;
    logic [7:0]  b_latq_reg;
    logic [8:0]  b_lonq_reg;
    logic [6:0]  c_latr_reg, c_lonr_reg;
    logic [30:0] c_latqe_reg, d_latqe_reg, e_latqe_reg;
    logic [31:0] c_lonqe_reg, d_lonqe_reg, e_lonqe_reg;
    logic [29:0] d_latx_reg, d_lonx_reg;
    logic [27:0] e_latq3_reg, e_lonq3_reg;
    logic [29:0] f_lat_reg;
    logic [30:0] f_lon_reg;

    // ------------------------------------------------------------------
    // Flow control: a stage is free when empty or when the next one is
    // ------------------------------------------------------------------
    assign f_free = !f_valid_reg || m_tready;
    assign e_free = !e_valid_reg || f_free;
    assign d_free = !d_valid_reg || e_free;
    assign c_free = !c_valid_reg || d_free;
    assign b_free = !b_valid_reg || c_free;
    assign a_free = !a_valid_reg || b_free;

    assign in_fire  = in_valid_reg && (!emit || a_free);
    assign s_tready = !in_valid_reg || in_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            in_char_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    // ------------------------------------------------------------------
    // Parser: while no result waits on a full pipeline, one character per cycle
    // ------------------------------------------------------------------
    logic       is_digit;
    logic [3:0] digit;
    logic       frac_ok;

    assign is_digit = (in_char_reg >= CH_ZERO) && (in_char_reg <= CH_NINE);
    assign digit    = 4'(in_char_reg - CH_ZERO);

    always_comb
    begin
        fld_next     = fld_reg;
        done_next    = done_reg;
        point_next   = point_reg;
        fcnt_next    = fcnt_reg;
        started_next = started_reg;
        time_next    = time_reg;
        latw_next    = latw_reg;
        latf_next    = latf_reg;
        lonw_next    = lonw_reg;
        lonf_next    = lonf_reg;
        north_next   = north_reg;
        east_next    = east_reg;
        fix_next     = fix_reg;
        emit         = 1'b0;
        emit_side    = '0;
        emit_latw    = '0;
        emit_latf    = '0;
        emit_lonw    = '0;
        emit_lonf    = '0;
        frac_ok      = 1'b0;

        if (in_valid_reg)
        begin
            if (in_start_reg)
            begin
                fld_next     = '0;
                point_next   = 1'b0;
                fcnt_next    = '0;
                started_next = 1'b0;
                time_next    = '0;
                latw_next    = '0;
                latf_next    = '0;
                lonw_next    = '0;
                lonf_next    = '0;
                north_next   = 1'b0;
                east_next    = 1'b0;
                done_next    = 1'b0;
            end

            if (!done_next)
            begin
                if (in_char_reg == CH_CR || in_char_reg == CH_LF)
                begin
                    // line end before the sentence completed
                    emit             = 1'b1;
                    emit_side.status = (fld_next == '0) ? ST_NO_SEP : ST_TRUNC;
                    emit_side.fix    = fix_next;
                    done_next        = 1'b1;
                end
                else if (in_char_reg == CH_COMMA)
                begin
                    if (fld_next >= FLD_EW)
                    begin
                        emit             = 1'b1;
                        emit_side.status = ST_OK;
                        emit_side.utc    = time_next;
                        emit_side.fix    = fix_next;
                        emit_side.north  = north_next;
                        emit_side.east   = east_next;
                        emit_latw        = latw_next;
                        emit_latf        = latf_next;
                        emit_lonw        = lonw_next;
                        emit_lonf        = lonf_next;
                        done_next        = 1'b1;
                    end
                    else
                    begin
                        fld_next     = fld_next + 3'd1;
                        point_next   = 1'b0;
                        fcnt_next    = '0;
                        started_next = 1'b0;
                    end
                end
                else
                begin
                    // first character of a letter field
                    if (!started_next)
                    begin
                        if (fld_next == FLD_STATUS)
                        begin
                            if (in_char_reg == CH_A)
                            begin
                                fix_next = 1'b1;
                            end
                            else if (in_char_reg == CH_V)
                            begin
                                fix_next = 1'b0;
                            end
                        end
                        else if (fld_next == FLD_NS)
                        begin
                            north_next = (in_char_reg == CH_N);
                        end
                        else if (fld_next == FLD_EW)
                        begin
                            east_next = (in_char_reg == CH_E);
                        end
                    end
                    started_next = 1'b1;

                    if (fld_next == FLD_TIME || fld_next == FLD_LAT
                        || fld_next == FLD_LON)
                    begin
                        frac_ok = ({1'b0, fcnt_next} < FD);
                        if (in_char_reg == CH_POINT)
                        begin
                            point_next = 1'b1;
                        end
                        else if (is_digit)
                        begin
                            if (fld_next == FLD_TIME)
                            begin
                                if (!point_next)
                                begin
                                    time_next = acc_sat(time_next, digit, TIME_MAX);
                                end
                            end
                            else if (!point_next)
                            begin
                                if (fld_next == FLD_LAT)
                                begin
                                    latw_next = 14'(acc_sat(18'(latw_next), digit,
                                                            LATW_MAX));
                                end
                                else
                                begin
                                    lonw_next = 15'(acc_sat(18'(lonw_next), digit,
                                                            LONW_MAX));
                                end
                            end
                            else if (frac_ok)
                            begin
                                // fraction kept at a fixed 7-digit scale
                                if (fld_next == FLD_LAT)
                                begin
                                    latf_next = latf_next + 24'(28'(digit)
                                        * 28'(POW10[fcnt_next]));
                                end
                                else
                                begin
                                    lonf_next = lonf_next + 24'(28'(digit)
                                        * 28'(POW10[fcnt_next]));
                                end
                                fcnt_next = fcnt_next + 3'd1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fld_reg     <= '0;
            done_reg    <= 1'b1;
            point_reg   <= 1'b0;
            fcnt_reg    <= '0;
            started_reg <= 1'b0;
            time_reg    <= '0;
            latw_reg    <= '0;
            latf_reg    <= '0;
            lonw_reg    <= '0;
            lonf_reg    <= '0;
            north_reg   <= 1'b0;
            east_reg    <= 1'b0;
            fix_reg     <= 1'b0;
        end
        else if (in_fire)
        begin
            fld_reg     <= fld_next;
            done_reg    <= done_next;
            point_reg   <= point_next;
            fcnt_reg    <= fcnt_next;
            started_reg <= started_next;
            time_reg    <= time_next;
            latw_reg    <= latw_next;
            latf_reg    <= latf_next;
            lonw_reg    <= lonw_next;
            lonf_reg    <= lonf_next;
            north_reg   <= north_next;
            east_reg    <= east_next;
            fix_reg     <= fix_next;
        end
    end

    // ------------------------------------------------------------------
    // Conversion pipeline
    //   value = (W / 100) * 1e7 + floor(((W % 100) * 1e7 + F7) / 60)
    //   with F7 the minute fraction scaled to seven digits
    // ------------------------------------------------------------------
    logic [26:0] latw_prod;
    logic [27:0] lonw_prod;
    logic [14:0] latq100;
    logic [15:0] lonq100;
    logic [30:0] latr_e7;
    logic [30:0] lonr_e7;
    logic [63:0] latx_prod;
    logic [63:0] lonx_prod;
    logic [31:0] lat_sum;
    logic [31:0] lon_sum;

    assign latw_prod = 27'(a_latw_reg) * 27'(RECIP_100);
    assign lonw_prod = 28'(a_lonw_reg) * 28'(RECIP_100);
    assign latq100   = 15'(b_latq_reg) * 15'd100;
    assign lonq100   = 16'(b_lonq_reg) * 16'd100;
    assign latr_e7   = 31'(c_latr_reg) * 31'(E7);
    assign lonr_e7   = 31'(c_lonr_reg) * 31'(E7);
    assign latx_prod = 64'(d_latx_reg[29:2]) * 64'(RECIP_15);
    assign lonx_prod = 64'(d_lonx_reg[29:2]) * 64'(RECIP_15);
    assign lat_sum   = 32'(e_latqe_reg) + 32'(e_latq3_reg);
    assign lon_sum   = e_lonqe_reg + 32'(e_lonq3_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free) a_valid_reg <= in_valid_reg && emit;
            if (b_free) b_valid_reg <= a_valid_reg;
            if (c_free) c_valid_reg <= b_valid_reg;
            if (d_free) d_valid_reg <= c_valid_reg;
            if (e_free) e_valid_reg <= d_valid_reg;
            if (f_free) f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // A: raw fields captured from the parser
        if (a_free)
        begin
            a_side_reg <= emit_side;
            a_latw_reg <= emit_latw;
            a_latf_reg <= emit_latf;
            a_lonw_reg <= emit_lonw;
            a_lonf_reg <= emit_lonf;
        end
        // B: whole degrees by reciprocal multiply
        if (b_free)
        begin
            b_side_reg <= a_side_reg;
            b_latq_reg <= 8'(latw_prod >> RECIP_SH);
            b_lonq_reg <= 9'(lonw_prod >> RECIP_SH);
            b_latw_reg <= a_latw_reg;
            b_lonw_reg <= a_lonw_reg;
            b_latf_reg <= a_latf_reg;
            b_lonf_reg <= a_lonf_reg;
        end
        // C: whole minutes and degrees * 1e7
        if (c_free)
        begin
            c_side_reg  <= b_side_reg;
            c_latr_reg  <= 7'(15'(b_latw_reg) - latq100);
            c_lonr_reg  <= 7'(16'(b_lonw_reg) - lonq100);
            c_latqe_reg <= 31'(b_latq_reg) * 31'(E7);
            c_lonqe_reg <= 32'(33'(b_lonq_reg) * 33'(E7));
            c_latf_reg  <= b_latf_reg;
            c_lonf_reg  <= b_lonf_reg;
        end
        // D: minutes at 7-digit scale
        if (d_free)
        begin
            d_side_reg  <= c_side_reg;
            d_latx_reg  <= 30'(latr_e7 + 31'(c_latf_reg));
            d_lonx_reg  <= 30'(lonr_e7 + 31'(c_lonf_reg));
            d_latqe_reg <= c_latqe_reg;
            d_lonqe_reg <= c_lonqe_reg;
        end
        // E: minutes / 60 -> floor(x / 4 / 15)
        if (e_free)
        begin
            e_side_reg  <= d_side_reg;
            e_latq3_reg <= latx_prod[59:32];
            e_lonq3_reg <= lonx_prod[59:32];
            e_latqe_reg <= d_latqe_reg;
            e_lonqe_reg <= d_lonqe_reg;
        end
        // F: add and saturate, output register
        if (f_free)
        begin
            f_side_reg <= e_side_reg;
            f_lat_reg  <= (lat_sum > LAT_LIMIT) ? 30'(LAT_LIMIT) : 30'(lat_sum);
            f_lon_reg  <= (lon_sum > LON_LIMIT) ? 31'(LON_LIMIT) : 31'(lon_sum);
        end
    end

    assign m_tvalid = f_valid_reg;
    assign m_tuser  = f_side_reg.status;
    assign m_tdata  = {6'd0, f_side_reg.east, f_lon_reg, f_side_reg.north,
                       f_lat_reg, f_side_reg.fix, f_side_reg.utc};

`ifndef SYNTHESIS
    // input only backs up when every result stage is full and blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while pipeline has room");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata[48:19] == '0
            && m_tdata[80:50] == '0 && m_tdata[17:0] == '0))
        else $error("error result carries position or time");

    a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(m_tdata[48:19]) <= LAT_LIMIT
            && 32'(m_tdata[80:50]) <= LON_LIMIT))
        else $error("position out of range");

    a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
        fld_reg <= FLD_EW)
        else $error("field counter past last field");

    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && emit) |=> done_reg)
        else $error("sentence not closed after result");
`endif

endmodule
